>>> src/fha_pkg.sv
`timescale 1ns / 1ps

package fha_pkg;

  localparam int HEAP_BYTES   = 4194304;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_SEGMENTS = 1024;

  localparam int IW     = $clog2(MAX_SEGMENTS);
  localparam int LW     = IW + 1;
  localparam int SZ_W   = $clog2(HEAP_BYTES + 1);
  localparam int CW     = 26;
  localparam int REQ_W  = 23;
  localparam int ADDR_W = 22;
  localparam int ST_W   = 3;
  localparam int CMD_W  = 4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 3'd1;
  localparam logic [ST_W-1:0] ST_OOM     = 3'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CMD_W-1:0] C_NOP     = 4'd0;
  localparam logic [CMD_W-1:0] C_INIT    = 4'd1;
  localparam logic [CMD_W-1:0] C_TRIV    = 4'd2;
  localparam logic [CMD_W-1:0] C_START   = 4'd3;
  localparam logic [CMD_W-1:0] C_STEP    = 4'd4;
  localparam logic [CMD_W-1:0] C_OOM     = 4'd5;
  localparam logic [CMD_W-1:0] C_DBL     = 4'd6;
  localparam logic [CMD_W-1:0] C_UNK     = 4'd7;
  localparam logic [CMD_W-1:0] C_FIT     = 4'd8;
  localparam logic [CMD_W-1:0] C_WR_BLK  = 4'd9;
  localparam logic [CMD_W-1:0] C_RD_FIX  = 4'd10;
  localparam logic [CMD_W-1:0] C_WR_FIX  = 4'd11;
  localparam logic [CMD_W-1:0] C_FBLK    = 4'd12;
  localparam logic [CMD_W-1:0] C_MERGE_R = 4'd13;
  localparam logic [CMD_W-1:0] C_RD_PV   = 4'd14;
  localparam logic [CMD_W-1:0] C_MERGE_L = 4'd15;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] address;
  } in_req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] granted_address;
  } out_res_t;

  typedef struct packed {
    logic [SZ_W-1:0] start;
    logic [SZ_W-1:0] size;
    logic            free;
    logic [LW-1:0]   nxt;
    logic [LW-1:0]   prv;
  } seg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             emit;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic trivial;
    logic fit;
    logic qfree;
    logic qnext_ok;
    logic match;
    logic split;
    logic fix_ok;
    logic bnext_ok;
    logic bprev_ok;
    logic out_busy;
  } dp_stat_t;

  function automatic logic link_ok(input logic [LW-1:0] x);
    return x < LW'(MAX_SEGMENTS);
  endfunction

endpackage

>>> src/fha_seg_ram.sv
`timescale 1ns / 1ps

module fha_seg_ram (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [fha_pkg::IW-1:0] wr_addr,
  input  fha_pkg::seg_t          wr_data,
  input  logic                   rd_en,
  input  logic [fha_pkg::IW-1:0] rd_addr,
  output fha_pkg::seg_t          rd_q
);

  fha_pkg::seg_t mem [fha_pkg::MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

>>> src/fha_slot_pool.sv
`timescale 1ns / 1ps

module fha_slot_pool (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop,
  input  logic                   push,
  input  logic [fha_pkg::IW-1:0] push_idx,
  output logic                   avail,
  output logic [fha_pkg::IW-1:0] pop_idx
);

  logic [fha_pkg::IW-1:0] stack [fha_pkg::MAX_SEGMENTS];
  logic [fha_pkg::LW-1:0] sp_r, sp_nxt;
  logic [fha_pkg::LW-1:0] fc_r, fc_nxt;
  logic [fha_pkg::LW-1:0] sp_dec;
  logic [fha_pkg::IW-1:0] top_q;

  assign sp_dec  = sp_r - fha_pkg::LW'(1);
  assign avail   = (sp_r != '0) || (fc_r < fha_pkg::LW'(fha_pkg::MAX_SEGMENTS));
  assign pop_idx = (sp_r != '0) ? top_q : fc_r[fha_pkg::IW-1:0];

  always_comb begin
    sp_nxt = sp_r;
    fc_nxt = fc_r;
    if (push) begin
      sp_nxt = sp_r + fha_pkg::LW'(1);
    end else if (pop) begin
      if (sp_r != '0) begin
        sp_nxt = sp_dec;
      end else begin
        fc_nxt = fc_r + fha_pkg::LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      fc_r <= fha_pkg::LW'(1);
    end else begin
      sp_r <= sp_nxt;
      fc_r <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack[sp_r[fha_pkg::IW-1:0]] <= push_idx;
    end
    top_q <= stack[sp_dec[fha_pkg::IW-1:0]];
  end

endmodule

>>> src/fha_datapath.sv
`timescale 1ns / 1ps

module fha_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  fha_pkg::dp_cmd_t    ctl,
  output fha_pkg::dp_stat_t   st,
  input  fha_pkg::in_req_t    in_data,
  output fha_pkg::out_res_t   out_data,
  output logic                out_valid,
  input  logic                out_stall
);

  localparam int IW = fha_pkg::IW;
  localparam int LW = fha_pkg::LW;
  localparam int SZ_W = fha_pkg::SZ_W;
  localparam int CW = fha_pkg::CW;

  fha_pkg::seg_t q, wdata, brec_r, brec_nxt;
  logic wr_en, rd_en, pop, push;
  logic [IW-1:0] waddr, raddr, push_idx, pop_idx, cur_r, cur_nxt, blk_r, blk_nxt;
  logic avail;
  logic op_r, op_nxt, split_r, split_nxt, split_want;
  logic [CW-1:0] total_r, total_nxt, round_up, q_pay;
  logic [fha_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [LW-1:0] fix_idx_r, fix_idx_nxt, fix_val_r, fix_val_nxt;
  fha_pkg::out_res_t res_r, res_nxt, out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  fha_seg_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(waddr), .wr_data(wdata),
    .rd_en(rd_en), .rd_addr(raddr), .rd_q(q)
  );

  fha_slot_pool u_pool (
    .clk(clk), .rst_n(rst_n), .pop(pop), .push(push), .push_idx(push_idx),
    .avail(avail), .pop_idx(pop_idx)
  );

  assign round_up   = CW'(in_data.request_size) + CW'(3);
  assign q_pay      = CW'(q.start) + CW'(fha_pkg::HEADER_BYTES);
  assign split_want = CW'(q.size) > total_r + CW'(fha_pkg::HEADER_BYTES + 4);

  assign st.op       = op_r;
  assign st.trivial  = (in_data.operation == fha_pkg::OP_ALLOC) ?
                       (in_data.request_size == '0) : (in_data.address == '0);
  assign st.fit      = q.free && (CW'(q.size) >= total_r);
  assign st.qfree    = q.free;
  assign st.qnext_ok = fha_pkg::link_ok(q.nxt);
  assign st.match    = q_pay == CW'(addr_r);
  assign st.split    = split_r;
  assign st.fix_ok   = fha_pkg::link_ok(fix_idx_r);
  assign st.bnext_ok = fha_pkg::link_ok(brec_r.nxt);
  assign st.bprev_ok = fha_pkg::link_ok(brec_r.prv);
  assign st.out_busy = out_valid_r && out_stall;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    wr_en       = 1'b0;
    waddr       = '0;
    wdata       = q;
    rd_en       = 1'b0;
    raddr       = '0;
    pop         = 1'b0;
    push        = 1'b0;
    push_idx    = '0;
    op_nxt      = op_r;
    total_nxt   = total_r;
    addr_nxt    = addr_r;
    cur_nxt     = cur_r;
    blk_nxt     = blk_r;
    brec_nxt    = brec_r;
    split_nxt   = split_r;
    fix_idx_nxt = fix_idx_r;
    fix_val_nxt = fix_val_r;
    res_nxt     = res_r;
    case (ctl.cmd)
      fha_pkg::C_INIT: begin
        wr_en       = 1'b1;
        waddr       = '0;
        wdata.start = '0;
        wdata.size  = SZ_W'(fha_pkg::HEAP_BYTES);
        wdata.free  = 1'b1;
        wdata.nxt   = LW'(fha_pkg::MAX_SEGMENTS);
        wdata.prv   = LW'(fha_pkg::MAX_SEGMENTS);
      end
      fha_pkg::C_TRIV: begin
        res_nxt.status          = fha_pkg::ST_IGNORED;
        res_nxt.granted_address = '0;
      end
      fha_pkg::C_START: begin
        op_nxt    = in_data.operation;
        total_nxt = {round_up[CW-1:2], 2'b00} + CW'(fha_pkg::HEADER_BYTES);
        addr_nxt  = in_data.address;
        cur_nxt   = '0;
        rd_en     = 1'b1;
        raddr     = '0;
      end
      fha_pkg::C_STEP: begin
        cur_nxt = q.nxt[IW-1:0];
        rd_en   = 1'b1;
        raddr   = q.nxt[IW-1:0];
      end
      fha_pkg::C_OOM: begin
        res_nxt.status          = fha_pkg::ST_OOM;
        res_nxt.granted_address = '0;
      end
      fha_pkg::C_DBL: begin
        res_nxt.status          = fha_pkg::ST_DOUBLE;
        res_nxt.granted_address = '0;
      end
      fha_pkg::C_UNK: begin
        res_nxt.status          = fha_pkg::ST_UNKNOWN;
        res_nxt.granted_address = '0;
      end
      fha_pkg::C_FIT: begin
        blk_nxt                 = cur_r;
        brec_nxt                = q;
        brec_nxt.free           = 1'b0;
        res_nxt.status          = fha_pkg::ST_OK;
        res_nxt.granted_address = q_pay[fha_pkg::ADDR_W-1:0];
        split_nxt               = split_want && avail;
        if (split_want && avail) begin
          pop           = 1'b1;
          brec_nxt.size = total_r[SZ_W-1:0];
          brec_nxt.nxt  = {1'b0, pop_idx};
          wr_en         = 1'b1;
          waddr         = pop_idx;
          wdata.start   = q.start + total_r[SZ_W-1:0];
          wdata.size    = q.size - total_r[SZ_W-1:0];
          wdata.free    = 1'b1;
          wdata.nxt     = q.nxt;
          wdata.prv     = {1'b0, cur_r};
          fix_idx_nxt   = q.nxt;
          fix_val_nxt   = {1'b0, pop_idx};
        end
      end
      fha_pkg::C_WR_BLK: begin
        wr_en = 1'b1;
        waddr = blk_r;
        wdata = brec_r;
        rd_en = 1'b1;
        raddr = fix_idx_r[IW-1:0];
      end
      fha_pkg::C_RD_FIX: begin
        rd_en = 1'b1;
        raddr = fix_idx_r[IW-1:0];
      end
      fha_pkg::C_WR_FIX: begin
        wr_en     = 1'b1;
        waddr     = fix_idx_r[IW-1:0];
        wdata     = q;
        wdata.prv = fix_val_r;
      end
      fha_pkg::C_FBLK: begin
        blk_nxt                 = cur_r;
        brec_nxt                = q;
        brec_nxt.free           = 1'b1;
        res_nxt.status          = fha_pkg::ST_OK;
        res_nxt.granted_address = '0;
        rd_en                   = 1'b1;
        raddr                   = q.nxt[IW-1:0];
      end
      fha_pkg::C_MERGE_R: begin
        push          = 1'b1;
        push_idx      = brec_r.nxt[IW-1:0];
        brec_nxt.size = brec_r.size + q.size;
        brec_nxt.nxt  = q.nxt;
        fix_idx_nxt   = q.nxt;
        fix_val_nxt   = {1'b0, blk_r};
      end
      fha_pkg::C_RD_PV: begin
        rd_en = 1'b1;
        raddr = brec_r.prv[IW-1:0];
      end
      fha_pkg::C_MERGE_L: begin
        wr_en       = 1'b1;
        waddr       = brec_r.prv[IW-1:0];
        wdata       = q;
        wdata.size  = q.size + brec_r.size;
        wdata.nxt   = brec_r.nxt;
        push        = 1'b1;
        push_idx    = blk_r;
        fix_idx_nxt = brec_r.nxt;
        fix_val_nxt = brec_r.prv;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.emit) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    total_r   <= total_nxt;
    addr_r    <= addr_nxt;
    cur_r     <= cur_nxt;
    blk_r     <= blk_nxt;
    brec_r    <= brec_nxt;
    split_r   <= split_nxt;
    fix_idx_r <= fix_idx_nxt;
    fix_val_r <= fix_val_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

endmodule

>>> src/fha_ctrl.sv
`timescale 1ns / 1ps

module fha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fha_pkg::dp_stat_t st,
  output fha_pkg::dp_cmd_t  ctl
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_FIT_WB = 4'd3;
  localparam logic [3:0] S_RDFIX  = 4'd4;
  localparam logic [3:0] S_WRFIX  = 4'd5;
  localparam logic [3:0] S_CHK_NX = 4'd6;
  localparam logic [3:0] S_PV     = 4'd7;
  localparam logic [3:0] S_CHK_PV = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ctl.cmd   = fha_pkg::C_NOP;
    ctl.emit  = 1'b0;
    case (state_r)
      S_INIT: begin
        ctl.cmd   = fha_pkg::C_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (st.trivial) begin
            ctl.cmd   = fha_pkg::C_TRIV;
            state_nxt = S_DONE;
          end else begin
            ctl.cmd   = fha_pkg::C_START;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (st.op == fha_pkg::OP_ALLOC) begin
          if (st.fit) begin
            ctl.cmd   = fha_pkg::C_FIT;
            state_nxt = S_FIT_WB;
          end else if (!st.qnext_ok) begin
            ctl.cmd   = fha_pkg::C_OOM;
            state_nxt = S_DONE;
          end else begin
            ctl.cmd = fha_pkg::C_STEP;
          end
        end else begin
          if (st.match) begin
            if (st.qfree) begin
              ctl.cmd   = fha_pkg::C_DBL;
              state_nxt = S_DONE;
            end else begin
              ctl.cmd   = fha_pkg::C_FBLK;
              state_nxt = st.qnext_ok ? S_CHK_NX : S_PV;
            end
          end else if (!st.qnext_ok) begin
            ctl.cmd   = fha_pkg::C_UNK;
            state_nxt = S_DONE;
          end else begin
            ctl.cmd = fha_pkg::C_STEP;
          end
        end
      end
      S_FIT_WB: begin
        ctl.cmd = fha_pkg::C_WR_BLK;
        if (st.split && st.fix_ok) begin
          ret_nxt   = S_DONE;
          state_nxt = S_WRFIX;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDFIX: begin
        ctl.cmd   = fha_pkg::C_RD_FIX;
        state_nxt = S_WRFIX;
      end
      S_WRFIX: begin
        ctl.cmd   = fha_pkg::C_WR_FIX;
        state_nxt = ret_r;
      end
      S_CHK_NX: begin
        if (st.qfree) begin
          ctl.cmd = fha_pkg::C_MERGE_R;
          if (st.qnext_ok) begin
            ret_nxt   = S_PV;
            state_nxt = S_RDFIX;
          end else begin
            state_nxt = S_PV;
          end
        end else begin
          state_nxt = S_PV;
        end
      end
      S_PV: begin
        if (st.bprev_ok) begin
          ctl.cmd   = fha_pkg::C_RD_PV;
          state_nxt = S_CHK_PV;
        end else begin
          ctl.cmd   = fha_pkg::C_WR_BLK;
          state_nxt = S_DONE;
        end
      end
      S_CHK_PV: begin
        if (st.qfree) begin
          ctl.cmd = fha_pkg::C_MERGE_L;
          if (st.bnext_ok) begin
            ret_nxt   = S_DONE;
            state_nxt = S_RDFIX;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ctl.cmd   = fha_pkg::C_WR_BLK;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ret_r   <= S_DONE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

>>> src/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// Channel   Ports                           Direction
// request   in_valid, in_stall, in_data     into the block
// result    out_valid, out_stall, out_data  out of the block
//
// A request walks the segment list in address order, reading one segment at a
// time through the single read port of the segment memory, and then splits
// or merges segments where it can.
// After reset the initial segment is written while in_stall is high.
// The finished result waits in an output register; the next request is taken
// meanwhile and only its result waits for out_stall to fall.
module first_fit_heap_allocator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fha_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fha_pkg::out_res_t out_data
);

  fha_pkg::dp_cmd_t  ctl;
  fha_pkg::dp_stat_t st;

  fha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .st(st), .ctl(ctl)
  );

  fha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st), .in_data(in_data),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

>>> src/fha_checker.sv
`timescale 1ns / 1ps

module fha_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input fha_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input fha_pkg::out_res_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> $stable(in_data))
    else $error("stalled request changed");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != fha_pkg::ST_OK) |-> out_data.granted_address == '0)
    else $error("failed request carries an address");

endmodule

bind first_fit_heap_allocator_core fha_checker u_fha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

>>> tb/first_fit_heap_allocator_core_test.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_test;

  localparam int NIL = fha_pkg::MAX_SEGMENTS;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  fha_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  fha_pkg::out_res_t out_data;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the segment table.
  int unsigned sh_start [fha_pkg::MAX_SEGMENTS];
  int unsigned sh_size [fha_pkg::MAX_SEGMENTS];
  bit sh_free [fha_pkg::MAX_SEGMENTS];
  int sh_next [fha_pkg::MAX_SEGMENTS];
  int sh_prev [fha_pkg::MAX_SEGMENTS];
  bit sh_used [fha_pkg::MAX_SEGMENTS];

  fha_pkg::in_req_t pending_reqs[$];
  fha_pkg::out_res_t expected_results[$];
  int unsigned live_addrs[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  bit in_taken = 0;
  longint cycle_count = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic table_reset();
    for (int i = 0; i < fha_pkg::MAX_SEGMENTS; i++) begin
      sh_start[i] = 0;
      sh_size[i] = 0;
      sh_free[i] = 0;
      sh_used[i] = 0;
      sh_next[i] = NIL;
      sh_prev[i] = NIL;
    end
    sh_size[0] = fha_pkg::HEAP_BYTES;
    sh_free[0] = 1;
    sh_used[0] = 1;
  endtask

  function automatic int lowest_unused_slot();
    for (int i = 0; i < fha_pkg::MAX_SEGMENTS; i++) if (!sh_used[i]) return i;
    return NIL;
  endfunction

  function automatic fha_pkg::out_res_t predict_alloc(int unsigned req);
    fha_pkg::out_res_t r;
    longint total;
    int cur;
    int ns;
    int nx;
    r = '0;
    if (req == 0) begin
      r.status = fha_pkg::ST_IGNORED;
      return r;
    end
    total = ((longint'(req) + 3) & ~longint'(3)) + fha_pkg::HEADER_BYTES;
    cur = 0;
    for (int g = 0; g < fha_pkg::MAX_SEGMENTS && cur < NIL; g++) begin
      if (sh_free[cur] && longint'(sh_size[cur]) >= total) begin
        if (longint'(sh_size[cur]) > total + fha_pkg::HEADER_BYTES + 4) begin
          ns = lowest_unused_slot();
          if (ns < NIL) begin
            nx = sh_next[cur];
            sh_used[ns] = 1;
            sh_start[ns] = sh_start[cur] + int'(total);
            sh_size[ns] = sh_size[cur] - int'(total);
            sh_free[ns] = 1;
            sh_prev[ns] = cur;
            sh_next[ns] = nx;
            if (nx < NIL) sh_prev[nx] = ns;
            sh_next[cur] = ns;
            sh_size[cur] = int'(total);
          end
        end
        sh_free[cur] = 0;
        r.status = fha_pkg::ST_OK;
        r.granted_address = fha_pkg::ADDR_W'(sh_start[cur] + fha_pkg::HEADER_BYTES);
        return r;
      end
      cur = sh_next[cur];
    end
    r.status = fha_pkg::ST_OOM;
    return r;
  endfunction

  function automatic void drop_slot(int s);
    sh_used[s] = 0;
    sh_free[s] = 0;
    sh_next[s] = NIL;
    sh_prev[s] = NIL;
  endfunction

  function automatic fha_pkg::out_res_t predict_free(int unsigned addr);
    fha_pkg::out_res_t r;
    int cur;
    int blk;
    int nx;
    int nn;
    int pv;
    int bn;
    r = '0;
    if (addr == 0) begin
      r.status = fha_pkg::ST_IGNORED;
      return r;
    end
    blk = NIL;
    cur = 0;
    for (int g = 0; g < fha_pkg::MAX_SEGMENTS && cur < NIL; g++) begin
      if (longint'(sh_start[cur]) + fha_pkg::HEADER_BYTES == longint'(addr)) begin
        blk = cur;
        break;
      end
      cur = sh_next[cur];
    end
    if (blk == NIL) begin
      r.status = fha_pkg::ST_UNKNOWN;
      return r;
    end
    if (sh_free[blk]) begin
      r.status = fha_pkg::ST_DOUBLE;
      return r;
    end
    sh_free[blk] = 1;
    nx = sh_next[blk];
    if (nx < NIL && sh_free[nx]) begin
      nn = sh_next[nx];
      sh_size[blk] += sh_size[nx];
      sh_next[blk] = nn;
      if (nn < NIL) sh_prev[nn] = blk;
      drop_slot(nx);
    end
    pv = sh_prev[blk];
    if (pv < NIL && sh_free[pv]) begin
      bn = sh_next[blk];
      sh_size[pv] += sh_size[blk];
      sh_next[pv] = bn;
      if (bn < NIL) sh_prev[bn] = pv;
      drop_slot(blk);
    end
    r.status = fha_pkg::ST_OK;
    return r;
  endfunction

  task automatic queue_alloc(int unsigned sz);
    fha_pkg::in_req_t q;
    q.operation = fha_pkg::OP_ALLOC;
    q.request_size = fha_pkg::REQ_W'(sz);
    q.address = fha_pkg::ADDR_W'($urandom);
    pending_reqs.push_back(q);
  endtask

  task automatic queue_free(int unsigned addr);
    fha_pkg::in_req_t q;
    q.operation = fha_pkg::OP_FREE;
    q.request_size = fha_pkg::REQ_W'($urandom);
    q.address = fha_pkg::ADDR_W'(addr);
    pending_reqs.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  function automatic int unsigned random_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 64);
    if (k < 90) return $urandom_range(65, 2048);
    if (k < 97) return $urandom_range(2049, 65536);
    return $urandom_range(0, (1 << 23) - 1);
  endfunction

  task automatic random_phase(int n);
    int k;
    int unsigned a;
    int idx;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50 || live_addrs.size() == 0) begin
        queue_alloc(random_size());
      end else if (k < 88) begin
        idx = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        queue_free(a);
      end else if (k < 94) begin
        queue_free($urandom_range(0, (1 << 22) - 1));
      end else begin
        queue_free(fha_pkg::HEADER_BYTES + 4 * $urandom_range(0, 300));
      end
    end
  endtask

  // The driver predicts at acceptance, so granted addresses are known here.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1;
      if (in_data.operation == fha_pkg::OP_ALLOC) begin
        fha_pkg::out_res_t r;
        r = predict_alloc(in_data.request_size);
        if (r.status == fha_pkg::ST_OK) live_addrs.push_back(r.granted_address);
        expected_results.push_back(r);
      end else begin
        expected_results.push_back(predict_free(in_data.address));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_taken = 0;
    end else if (in_valid && !in_taken) begin
    end else begin
      in_taken = 0;
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    fha_pkg::out_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%0h", $time,
                 out_data.status, out_data.granted_address);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.granted_address !== e.granted_address) begin
          $display("%0t: address expected %0h actual %0h", $time,
                   e.granted_address, out_data.granted_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    table_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    queue_alloc(0);
    queue_free(0);
    queue_alloc(1);
    queue_alloc(4);
    queue_alloc(5);
    queue_alloc(fha_pkg::HEAP_BYTES);
    queue_alloc(23'h7FFFFF);
    queue_free(fha_pkg::HEADER_BYTES);
    queue_free(fha_pkg::HEADER_BYTES);
    queue_free(22'h3FFFFF);
    queue_free(3);
    queue_alloc(8);
    queue_alloc(12);
    queue_alloc(16);
    queue_free(fha_pkg::HEADER_BYTES + 24);
    queue_free(fha_pkg::HEADER_BYTES);
    queue_free(fha_pkg::HEADER_BYTES + 48);
    queue_alloc(fha_pkg::HEAP_BYTES - 2 * fha_pkg::HEADER_BYTES);
    queue_alloc(fha_pkg::HEAP_BYTES - fha_pkg::HEADER_BYTES - 4);
    queue_alloc(fha_pkg::HEAP_BYTES - fha_pkg::HEADER_BYTES);
    queue_free(fha_pkg::HEADER_BYTES);
    wait_drained();
    live_addrs.delete();

    random_phase(110);
    wait_drained();

    send_idle_pct = 58;
    random_phase(80);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 58;
    random_phase(80);
    wait_drained();

    stall_pct = 38;
    send_idle_pct = 38;
    random_phase(80);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk);
    hold_cycles = 3000;
    random_phase(100);
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
